FILE: hdl/ring_buffer_substring_search_assert.svh
// Assertion helpers for the top-level RTL file. Each expects clk_i and rst_ni in scope.
`ifndef RING_BUFFER_SUBSTRING_SEARCH_ASSERT_SVH
`define RING_BUFFER_SUBSTRING_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define RBSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication.
`define RBSS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

FILE: hdl/rbss_pkg.sv
`timescale 1ns / 1ps

package rbss_pkg;

  localparam int OFFSET_W = 8;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_SEARCH = 2'd3
  } action_e;

  // Status of the scan engine as seen by the top level.
  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } scan_stat_t;

endpackage

FILE: hdl/ring_buffer_substring_search.sv
// Byte ring with a substring search. Push, pattern load and flush requests are taken
// one per cycle while the scan engine is idle. A search request runs on the scan engine,
// which compares one ring byte against one pattern byte per cycle through the single
// read port of the ring memory. A search with an empty pattern or an empty ring goes
// straight to its result without any byte comparison. No new request is taken while a
// search runs or its result waits in the scan engine; the output register lets the next
// request in while the previous result still waits to be taken. The memories need no
// clearing pass after reset.
`timescale 1ns / 1ps
`include "ring_buffer_substring_search_assert.svh"

module ring_buffer_substring_search #(
  parameter int RING_DEPTH  = 256,
  parameter int PATTERN_MAX = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  input  logic [3:0] pattern_index_i,
  input  logic [4:0] pattern_len_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       found_o,
  output logic [7:0] match_offset_o
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int JW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [PW-1:0] rp_q, rp_d;
  logic [PW-1:0] wp_q, wp_d;
  logic          out_valid_q, out_valid_d;
  logic          found_q;
  logic [rbss_pkg::OFFSET_W-1:0] offset_q;

  logic          in_accept;
  logic          ring_we;
  logic          pat_we;
  logic          start_search;
  logic [LW-1:0] len_sat;
  logic [PW-1:0] ring_raddr;
  logic [JW-1:0] pat_raddr;
  logic [JW-1:0] pat_waddr;
  logic [7:0]    ring_rdata;
  logic [7:0]    pat_rdata;
  logic          res_load;

  rbss_pkg::scan_stat_t          scan_stat;
  logic [rbss_pkg::OFFSET_W-1:0] scan_offset;

  assign in_ready_o = !scan_stat.busy;
  assign in_accept  = in_valid_i && in_ready_o;

  assign ring_we      = in_accept && (action_i == rbss_pkg::ACT_PUSH);
  assign pat_we       = in_accept && (action_i == rbss_pkg::ACT_LOAD)
                        && (32'(pattern_index_i) < 32'(PATTERN_MAX));
  assign start_search = in_accept && (action_i == rbss_pkg::ACT_SEARCH);
  assign pat_waddr    = JW'(32'(pattern_index_i));
  assign len_sat      = (32'(pattern_len_i) > 32'(PATTERN_MAX)) ? LW'(PATTERN_MAX)
                                                               : LW'(32'(pattern_len_i));

  always_comb begin
    rp_d = rp_q;
    wp_d = wp_q;
    if (in_accept) begin
      unique case (rbss_pkg::action_e'(action_i))
        rbss_pkg::ACT_PUSH: begin
          wp_d = (wp_q == PW'(RING_DEPTH - 1)) ? '0 : wp_q + PW'(1);
        end
        rbss_pkg::ACT_FLUSH: begin
          rp_d = wp_q;
        end
        rbss_pkg::ACT_LOAD, rbss_pkg::ACT_SEARCH: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign res_load    = scan_stat.done && (!out_valid_q || out_ready_i);
  assign out_valid_d = res_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      found_q  <= scan_stat.found;
      offset_q <= scan_offset;
    end
  end

  rbss_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ring_we),
    .wr_addr_i(wp_q),
    .wr_data_i(data_byte_i),
    .rd_addr_i(ring_raddr),
    .rd_data_o(ring_rdata)
  );

  rbss_ram #(
    .WIDTH(8),
    .DEPTH(PATTERN_MAX)
  ) u_pat_ram (
    .clk_i    (clk_i),
    .wr_en_i  (pat_we),
    .wr_addr_i(pat_waddr),
    .wr_data_i(data_byte_i),
    .rd_addr_i(pat_raddr),
    .rd_data_o(pat_rdata)
  );

  rbss_scan #(
    .RING_DEPTH (RING_DEPTH),
    .PATTERN_MAX(PATTERN_MAX)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_search),
    .len_i       (len_sat),
    .rp_i        (rp_q),
    .wp_i        (wp_q),
    .ring_rdata_i(ring_rdata),
    .pat_rdata_i (pat_rdata),
    .ring_raddr_o(ring_raddr),
    .pat_raddr_o (pat_raddr),
    .ack_i       (res_load),
    .stat_o      (scan_stat),
    .offset_o    (scan_offset)
  );

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

  // Pointers must not move under a running search.
  `RBSS_ASSERT_NXT(a_ptr_hold, scan_stat.busy, ($stable(wp_q) && $stable(rp_q)))
  // A miss always reports offset zero.
  `RBSS_ASSERT_IMP(a_miss_offset, (out_valid_o && !found_o), (match_offset_o == 8'd0))
  // A pending result is never overwritten before it is taken.
  `RBSS_ASSERT_NXT(a_out_hold, (out_valid_o && !out_ready_i),
                   (out_valid_o && $stable(found_o) && $stable(match_offset_o)))

endmodule

FILE: hdl/rbss_ram.sv
`timescale 1ns / 1ps

module rbss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                          wr_data_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                          rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/rbss_scan.sv
`timescale 1ns / 1ps

module rbss_scan #(
  parameter int RING_DEPTH  = 256,
  parameter int PATTERN_MAX = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic [$clog2(PATTERN_MAX+1)-1:0]              len_i,
  input  logic [$clog2(RING_DEPTH)-1:0]                 rp_i,
  input  logic [$clog2(RING_DEPTH)-1:0]                 wp_i,
  input  logic [7:0]                                    ring_rdata_i,
  input  logic [7:0]                                    pat_rdata_i,
  output logic [$clog2(RING_DEPTH)-1:0]                 ring_raddr_o,
  output logic [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] pat_raddr_o,
  input  logic                                          ack_i,
  output rbss_pkg::scan_stat_t                          stat_o,
  output logic [rbss_pkg::OFFSET_W-1:0]                 offset_o
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int JW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(RING_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_e;

  state_e                      state_q;
  logic [PW-1:0]               pos_q, pos_d;
  logic [PW-1:0]               start_q, start_d;
  logic [PW-1:0]               k_q, k_d;
  logic [JW-1:0]               j_q, j_d;
  logic [LW-1:0]               len_q;
  logic                        found_q;
  logic [rbss_pkg::OFFSET_W-1:0] offset_q;

  logic [PW-1:0] pos_inc;
  logic [PW-1:0] start_inc;
  logic          ring_zero;
  logic          byte_eq;
  logic          last_byte;
  logic          scan_end;
  logic          scan_hit;

  always_comb begin
    pos_inc   = (pos_q == LAST_POS) ? '0 : pos_q + PW'(1);
    start_inc = (start_q == LAST_POS) ? '0 : start_q + PW'(1);
    ring_zero = (ring_rdata_i == 8'd0);
    byte_eq   = (ring_rdata_i == pat_rdata_i);
    last_byte = ((32'(j_q) + 32'd1) == 32'(len_q));

    pos_d    = pos_q;
    start_d  = start_q;
    k_d      = k_q;
    j_d      = j_q;
    scan_end = 1'b0;
    scan_hit = 1'b0;

    // Read data for (k_q, j_q) arrives this cycle; the next compare is issued now.
    if (state_q == S_SCAN) begin
      priority if (ring_zero) begin
        scan_end = 1'b1;
      end else if (byte_eq) begin
        if (last_byte) begin
          scan_hit = 1'b1;
        end else begin
          pos_d = pos_inc;
          j_d   = j_q + JW'(1);
          if (pos_inc == wp_i) begin
            scan_end = 1'b1;
          end
        end
      end else begin
        // Mismatch: restart one byte further on with the first pattern byte.
        pos_d   = start_inc;
        start_d = start_inc;
        k_d     = k_q + PW'(1);
        j_d     = '0;
        if (start_inc == wp_i) begin
          scan_end = 1'b1;
        end
      end
    end

    ring_raddr_o = (state_q == S_SCAN) ? pos_d : rp_i;
    pat_raddr_o  = (state_q == S_SCAN) ? j_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pos_q    <= '0;
      start_q  <= '0;
      k_q      <= '0;
      j_q      <= '0;
      len_q    <= '0;
      found_q  <= 1'b0;
      offset_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            len_q    <= len_i;
            pos_q    <= rp_i;
            start_q  <= rp_i;
            k_q      <= '0;
            j_q      <= '0;
            offset_q <= '0;
            if (len_i == '0) begin
              found_q <= 1'b1;
              state_q <= S_HOLD;
            end else if (rp_i == wp_i) begin
              found_q <= 1'b0;
              state_q <= S_HOLD;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pos_q   <= pos_d;
          start_q <= start_d;
          k_q     <= k_d;
          j_q     <= j_d;
          if (scan_hit) begin
            found_q  <= 1'b1;
            offset_q <= rbss_pkg::OFFSET_W'(32'(k_q));
            state_q  <= S_HOLD;
          end else if (scan_end) begin
            found_q  <= 1'b0;
            offset_q <= '0;
            state_q  <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign stat_o.busy  = (state_q != S_IDLE);
  assign stat_o.done  = (state_q == S_HOLD);
  assign stat_o.found = found_q;
  assign offset_o     = offset_q;

endmodule

FILE: tb/ring_buffer_substring_search_checker.sv
`timescale 1ns / 1ps

module ring_buffer_substring_search_checker #(
  parameter int RING_DEPTH  = 256,
  parameter int PATTERN_MAX = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  input  logic [3:0] pattern_index_i,
  input  logic [4:0] pattern_len_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       found_i,
  input  logic [7:0] match_offset_i,
  output int         mismatch_cnt_o,
  output int         pending_o
);

  typedef struct {
    logic       found;
    logic [7:0] offset;
  } hit_t;

  logic [7:0]  ring_mem [RING_DEPTH];
  logic [7:0]  pat_mem  [PATTERN_MAX];
  int unsigned rd_ptr = 0;
  int unsigned wr_ptr = 0;
  hit_t        hit_q [$];

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
  end

  // First occurrence of the pattern inside the region that runs from the read
  // pointer up to the write pointer or the first zero byte.
  function automatic hit_t scan_ring(input int unsigned len_in);
    hit_t        h;
    int unsigned len;
    int unsigned n;
    bit          ok;
    h.found  = 1'b0;
    h.offset = 8'h00;
    len = (len_in > PATTERN_MAX) ? PATTERN_MAX : len_in;
    if (len == 0) begin
      h.found = 1'b1;
      return h;
    end
    n = 0;
    while (n < RING_DEPTH) begin
      if ((rd_ptr + n) % RING_DEPTH == wr_ptr || ring_mem[(rd_ptr + n) % RING_DEPTH] == 8'h00)
        break;
      n++;
    end
    if (n >= len) begin
      for (int unsigned k = 0; k + len <= n; k++) begin
        ok = 1'b1;
        for (int unsigned j = 0; j < len; j++) begin
          if (ring_mem[(rd_ptr + k + j) % RING_DEPTH] != pat_mem[j]) begin
            ok = 1'b0;
            break;
          end
        end
        if (ok) begin
          h.found  = 1'b1;
          h.offset = k[7:0];
          break;
        end
      end
    end
    return h;
  endfunction

  always @(posedge clk_i) begin : watch_proc
    hit_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        case (action_i)
          rbss_pkg::ACT_PUSH: begin
            ring_mem[wr_ptr] = data_byte_i;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
          end
          // Loads past the end of the pattern store are dropped.
          rbss_pkg::ACT_LOAD: begin
            if (int'(pattern_index_i) < PATTERN_MAX)
              pat_mem[pattern_index_i] = data_byte_i;
          end
          rbss_pkg::ACT_FLUSH:  rd_ptr = wr_ptr;
          rbss_pkg::ACT_SEARCH: hit_q.push_back(scan_ring(pattern_len_i));
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (hit_q.size() == 0) begin
          if (mismatch_cnt_o < 10)
            $display("mismatch: result found=%0d offset=%0d with no search pending",
                     found_i, match_offset_i);
          mismatch_cnt_o <= mismatch_cnt_o + 1;
        end else begin
          want = hit_q.pop_front();
          if (found_i !== want.found || match_offset_i !== want.offset) begin
            if (mismatch_cnt_o < 10)
              $display("mismatch: found expected %0d got %0d, offset expected %0d got %0d",
                       want.found, found_i, want.offset, match_offset_i);
            mismatch_cnt_o <= mismatch_cnt_o + 1;
          end
        end
      end
      pending_o <= hit_q.size();
    end
  end

endmodule

FILE: tb/ring_buffer_substring_search_test.sv
`timescale 1ns / 1ps

module ring_buffer_substring_search_test;

  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 20000000;

  typedef struct {
    rbss_pkg::action_e act;
    logic [7:0]        data;
    logic [3:0]        idx;
    logic [4:0]        len;
  } req_t;

  typedef enum int {BYTES_PAIR, BYTES_FOUR, BYTES_ANY} byte_set_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] action = rbss_pkg::ACT_PUSH;
  logic [7:0] data_byte = 8'h00;
  logic [3:0] pattern_index = 4'h0;
  logic [4:0] pattern_len = 5'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       found;
  logic [7:0] match_offset;
  logic       hold_off = 1'b0;

  int         mismatches;
  int         pending;
  int         next_item = 0;
  int         burst_left = 1;
  int         gap_left = 0;
  int         cycle_cnt = 0;
  rx_mode_e   rx_mode = RX_OPEN;
  int         rx_left = 0;
  int         rx_tick = 0;
  req_t       stim_q [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ring_buffer_substring_search i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (action),
    .data_byte_i     (data_byte),
    .pattern_index_i (pattern_index),
    .pattern_len_i   (pattern_len),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .found_o         (found),
    .match_offset_o  (match_offset)
  );

  ring_buffer_substring_search_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .action_i        (action),
    .data_byte_i     (data_byte),
    .pattern_index_i (pattern_index),
    .pattern_len_i   (pattern_len),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .found_i         (found),
    .match_offset_i  (match_offset),
    .mismatch_cnt_o  (mismatches),
    .pending_o       (pending)
  );

  // The wrappers below fill the fields a request does not use with random bits.
  function automatic void add_req(rbss_pkg::action_e a, int unsigned d, int unsigned ix,
                                  int unsigned ln);
    req_t r;
    r.act  = a;
    r.data = d[7:0];
    r.idx  = ix[3:0];
    r.len  = ln[4:0];
    stim_q.push_back(r);
  endfunction

  function automatic void add_push(int unsigned d);
    add_req(rbss_pkg::ACT_PUSH, d, $urandom_range(0, 15), $urandom_range(0, 31));
  endfunction

  function automatic void add_load(int unsigned ix, int unsigned d);
    add_req(rbss_pkg::ACT_LOAD, d, ix, $urandom_range(0, 31));
  endfunction

  function automatic void add_search(int unsigned ln);
    add_req(rbss_pkg::ACT_SEARCH, $urandom_range(0, 255), $urandom_range(0, 15), ln);
  endfunction

  // Small byte sets make matches and partial matches common.
  function automatic int unsigned pick_byte(byte_set_e set);
    if (set != BYTES_ANY && $urandom_range(0, 39) == 0)
      return 0;
    case (set)
      BYTES_PAIR: return $urandom_range(1, 2);
      BYTES_FOUR: return $urandom_range(1, 4);
      default:    return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic void build_stimulus();
    byte_set_e   set;
    int unsigned pat [16];
    int          plen;
    int          fill;
    int          at;
    int          r;
    int          long_runs;
    long_runs = 0;

    // Empty pattern on an empty ring, then a search of an empty ring.
    add_search(0);
    add_load(0, 8'h41);
    add_load(1, 8'h42);
    add_load(2, 8'h43);
    add_search(3);
    // A partial match that must be backed out of before the real one.
    add_push(8'h10);
    add_push(8'h41);
    add_push(8'h42);
    add_push(8'h41);
    add_push(8'h42);
    add_push(8'h43);
    add_search(2);
    add_search(3);
    // A zero pattern byte never matches.
    add_load(3, 8'h00);
    add_search(4);
    add_req(rbss_pkg::ACT_FLUSH, 8'hff, 4'hf, 5'h1f);
    add_search(0);
    // A leading zero byte closes the region at once.
    add_push(8'h00);
    add_push(8'h41);
    add_push(8'h42);
    add_push(8'h43);
    add_search(3);
    add_load(0, 8'hff);
    add_req(rbss_pkg::ACT_FLUSH, 8'h00, 4'h0, 5'h00);
    add_push(8'hff);
    add_search(1);

    // Every pattern entry is written before any longer search can read it.
    for (int i = 0; i < 16; i++)
      add_load(i, $urandom_range(0, 255));

    while (stim_q.size() < RANDOM_ITEMS + 40) begin
      r = $urandom_range(0, 9);
      set = (r < 4) ? BYTES_PAIR : (r < 8) ? BYTES_FOUR : BYTES_ANY;
      if ($urandom_range(0, 2) == 0)
        add_req(rbss_pkg::ACT_FLUSH, $urandom_range(0, 255), $urandom_range(0, 15),
                $urandom_range(0, 31));
      plen = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
      for (int i = 0; i < plen; i++) begin
        pat[i] = pick_byte(set);
        add_load(i, pat[i]);
      end
      if (long_runs < 2 && $urandom_range(0, 14) == 0) begin
        // Long runs without zeros take the pointers around and across each other.
        long_runs++;
        fill = $urandom_range(240, 270);
        for (int i = 0; i < fill; i++)
          add_push($urandom_range(1, 2));
      end else begin
        fill = $urandom_range(0, 30);
        at = $urandom_range(0, 1) ? $urandom_range(0, fill) : -1;
        for (int i = 0; i <= fill; i++) begin
          if (i == at) begin
            for (int j = 0; j < plen; j++)
              add_push(pat[j]);
          end
          if (i < fill)
            add_push(pick_byte(set));
        end
      end
      if ($urandom_range(0, 5) == 0)
        add_load($urandom_range(0, 15), $urandom_range(0, 255));
      r = $urandom_range(0, 9);
      if (r < 7)
        add_search(plen);
      else if (r == 7)
        add_search(0);
      else if (r == 8)
        add_search($urandom_range(17, 31));
      else
        add_search($urandom_range(1, 16));
      if ($urandom_range(0, 3) == 0) begin
        fill = $urandom_range(1, 6);
        for (int i = 0; i < fill; i++)
          add_push(pick_byte(set));
        add_search($urandom_range(0, 31));
      end
    end
  endfunction

  // Sender: bursts of random length, each followed by a random gap.
  always @(posedge clk) begin
    if (rst_n && (!in_valid || in_ready)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (next_item < stim_q.size()) begin
        in_valid      <= 1'b1;
        action        <= stim_q[next_item].act;
        data_byte     <= stim_q[next_item].data;
        pattern_index <= stim_q[next_item].idx;
        pattern_len   <= stim_q[next_item].len;
        next_item     <= next_item + 1;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: switches between stall patterns, each held for a random length of time.
  always @(posedge clk) begin : rx_proc
    logic rdy;
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   rdy = 1'b1;
      RX_COIN:   rdy = 1'($urandom_range(0, 1));
      RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
      default:   rdy = (rx_tick % 5 == 0);
    endcase
    out_ready <= rdy && !hold_off;
  end

  // One long hold-off on the result side while requests keep coming.
  initial begin
    @(posedge rst_n);
    while (next_item < stim_q.size() / 3)
      @(posedge clk);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (!(next_item == stim_q.size() && !in_valid))
      @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
